FILE: rtl/bcsc_pkg.sv
// Shared types, codes and constants of the battery charge state controller.
// Used by every module in the rtl folder; depends on nothing else.
package bcsc_pkg;

   // Charge machine state codes.
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_BAD   = 3'd2;
   localparam logic [2:0] ST_PRE   = 3'd3;
   localparam logic [2:0] ST_CHG   = 3'd4;
   localparam logic [2:0] ST_ERR   = 3'd5;
   localparam logic [2:0] ST_DIS   = 3'd6;

   // Battery status word bit positions.
   localparam int AL_OVER_CHARGED   = 15;
   localparam int AL_TERM_CHARGE    = 14;
   localparam int AL_OVER_TEMP      = 12;
   localparam int AL_TERM_DISCHARGE = 11;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIS_MIN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIS_MAX    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_TMO    = 3'd6;
   localparam int CSR_DATA_W = 20;

   // Register reset values.
   localparam logic signed [7:0] RST_START_MIN  = 8'sd0;
   localparam logic signed [7:0] RST_START_MAX  = 8'sd45;
   localparam logic signed [7:0] RST_CHARGE_MIN = 8'sd0;
   localparam logic signed [7:0] RST_CHARGE_MAX = 8'sd60;
   localparam logic signed [7:0] RST_DIS_MIN    = -8'sd20;
   localparam logic signed [7:0] RST_DIS_MAX    = 8'sd70;
   localparam logic [19:0]       RST_PRE_TMO    = 20'd15000;

   // Percent thresholds and timing.
   localparam int LOW_ENTER_PCT = 40;
   localparam int LOW_EXIT_PCT  = 60;
   localparam int FULL_PCT      = 100;
   localparam int SHUTDOWN_PCT  = 3;
   localparam int NOTICE_PCT    = 10;
   localparam logic [31:0] NOTICE_GAP_MS = 32'd60000;

   // Deci-kelvin to Celsius: offset, then divide by ten via reciprocal.
   localparam int DK_OFFSET  = 2731;
   localparam int DIV10_MUL  = 52429;
   localparam int DIV10_SHR  = 19;

   localparam int WINDOW_DEPTH_DEF = 4;

   // Input beat, last field in the lowest bits.
   typedef struct packed {
      logic        pad;
      logic [31:0] now_ms;
      logic [6:0]  charge_percent;
      logic        soc_valid;
      logic [15:0] alarm_bits;
      logic        status_valid;
      logic [15:0] battery_temp_dk;
      logic        temp_valid;
      logic        charge_timed_out;
      logic        charger_alarm;
      logic        host_off;
      logic        host_on;
      logic        ac_present;
   } item_type;

   // Result beat, last field in the lowest bits.
   typedef struct packed {
      logic       low_notice;
      logic       shutdown_request;
      logic       low_current_mode;
      logic       led_error;
      logic       charge_enable;
      logic [2:0] state_code;
   } result_type;

   typedef struct packed {
      logic signed [7:0] start_charge_min_c;
      logic signed [7:0] start_charge_max_c;
      logic signed [7:0] charge_min_c;
      logic signed [7:0] charge_max_c;
      logic signed [7:0] discharge_min_c;
      logic signed [7:0] discharge_max_c;
      logic [19:0]       precharge_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic start_ok;
      logic charge_ok;
      logic discharge_ok;
   } temp_flags_type;

   typedef struct packed {
      logic       clear;
      logic       push;
      logic [6:0] pct;
   } win_ctrl_type;

endpackage

FILE: rtl/bcsc_temp_eval.sv
// Converts the battery temperature to Celsius and checks it against the
// three configured windows. Depends on bcsc_pkg.
module bcsc_temp_eval
   import bcsc_pkg::*;
(
   input  logic [15:0]    battery_temp_dk,
   input  cfg_type        cfg,
   output temp_flags_type flags
);

   logic signed [17:0] diff;
   logic               neg;
   logic [15:0]        mag;
   logic [31:0]        prod;
   logic [12:0]        quot;
   logic signed [13:0] celsius;

   always_comb begin
      diff = $signed({2'b00, battery_temp_dk}) - 18'sd2731;
      neg  = diff[17];
      mag  = neg ? 16'(-diff) : diff[15:0];
      // Exact divide by ten for any 16-bit magnitude.
      prod = mag * 32'(DIV10_MUL);
      quot = prod[DIV10_SHR +: 13];
      // Truncation toward zero: divide the magnitude, then restore the sign.
      celsius = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   end

   assign flags.start_ok = (celsius >= 14'(cfg.start_charge_min_c)) &&
                           (celsius <  14'(cfg.start_charge_max_c));
   assign flags.charge_ok = (celsius >= 14'(cfg.charge_min_c)) &&
                            (celsius <  14'(cfg.charge_max_c));
   assign flags.discharge_ok = (celsius >= 14'(cfg.discharge_min_c)) &&
                               (celsius <  14'(cfg.discharge_max_c));

endmodule

FILE: rtl/bcsc_soc_window.sv
// State-of-charge averaging window with a running sum, used while
// discharging to spot a nearly empty battery. Depends on bcsc_pkg.
module bcsc_soc_window
   import bcsc_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  win_ctrl_type ctrl,
   output logic         avg_low
);

   localparam int POS_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W = $clog2(WINDOW_DEPTH * 128);
   localparam logic [SUM_W-1:0] HALF   = SUM_W'(WINDOW_DEPTH / 2);
   localparam logic [SUM_W-1:0] THRESH = SUM_W'(SHUTDOWN_PCT * WINDOW_DEPTH);
   localparam logic [POS_W-1:0] LAST   = POS_W'(WINDOW_DEPTH - 1);

   logic [6:0]       win_ff [WINDOW_DEPTH];
   logic [6:0]       fill_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             filled_ff, filled_in;
   logic             wrapped_ff, wrapped_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [6:0]       old_val;
   logic [SUM_W-1:0] pct_ext;

   always_comb begin
      pct_ext = SUM_W'(ctrl.pct);
      // Slots not yet rewritten since the last fill count as the fill value.
      old_val = wrapped_ff ? win_ff[pos_ff] : fill_ff;
      sum_in     = sum_ff;
      filled_in  = filled_ff;
      wrapped_in = wrapped_ff;
      pos_in     = pos_ff;
      if (!filled_ff) begin
         avg_low = ctrl.pct < 7'(SHUTDOWN_PCT);
      end else begin
         avg_low = ((sum_ff - SUM_W'(old_val) + pct_ext) + HALF) < THRESH;
      end
      if (ctrl.push) begin
         if (!filled_ff) begin
            sum_in     = SUM_W'(WINDOW_DEPTH) * pct_ext;
            filled_in  = 1'b1;
            wrapped_in = 1'b0;
            pos_in     = '0;
         end else begin
            sum_in = sum_ff - SUM_W'(old_val) + pct_ext;
            if (pos_ff == LAST) begin
               pos_in     = '0;
               wrapped_in = 1'b1;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
      if (ctrl.clear) begin
         filled_in = 1'b0;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff  <= 1'b0;
         wrapped_ff <= 1'b0;
         pos_ff     <= '0;
      end else if (advance) begin
         filled_ff  <= filled_in;
         wrapped_ff <= wrapped_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
         if (ctrl.push) begin
            if (!filled_ff) begin
               fill_ff <= ctrl.pct;
            end else begin
               win_ff[pos_ff] <= ctrl.pct;
            end
         end
      end
   end

endmodule

FILE: rtl/bcsc_charge_fsm.sv
// Seven-state charge machine with its timers, output levels and the
// low-battery notice limiter. Depends on bcsc_pkg.
module bcsc_charge_fsm
   import bcsc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  item_type       item,
   input  temp_flags_type temp,
   input  logic [19:0]    precharge_timeout_ms,
   input  logic           avg_low,
   output win_ctrl_type   win_ctrl,
   output result_type     result
);

   logic [2:0]  mode_ff, mode_in;
   logic [31:0] pre_start_ff, pre_start_in;
   logic [31:0] notice_time_ff, notice_time_in;
   logic        enable_ff, enable_in;
   logic        led_ff, led_in;
   logic        low_cur_ff, low_cur_in;
   logic [2:0]  cur;
   logic [31:0] pre_elapsed;
   logic [31:0] notice_elapsed;
   logic        changed;
   logic        shut;
   logic        notice;
   logic        push;
   logic        charged;

   function automatic logic low_current_from(input logic level, input logic [6:0] pct);
      logic res;
      res = level;
      if (pct < 7'(LOW_ENTER_PCT)) begin
         res = 1'b1;
      end else if (pct > 7'(LOW_EXIT_PCT)) begin
         res = 1'b0;
      end
      return res;
   endfunction

   always_comb begin
      cur = (mode_ff > ST_DIS) ? ST_INIT : mode_ff;
      mode_in        = cur;
      low_cur_in     = low_cur_ff;
      notice_time_in = notice_time_ff;
      shut           = 1'b0;
      notice         = 1'b0;
      push           = 1'b0;
      pre_elapsed    = item.now_ms - pre_start_ff;
      notice_elapsed = item.now_ms - notice_time_ff;
      charged        = item.alarm_bits[AL_OVER_CHARGED] | item.alarm_bits[AL_TERM_CHARGE];

      if (cur == ST_PRE && pre_elapsed >= 32'(precharge_timeout_ms)) begin
         mode_in = ST_ERR;
      end else begin
         case (cur)
            ST_PRE: begin
               if (!item.ac_present) begin
                  mode_in = ST_INIT;
               end else if (item.temp_valid) begin
                  if (!temp.start_ok) begin
                     mode_in = ST_INIT;
                  end else begin
                     mode_in = ST_CHG;
                     if (item.soc_valid) begin
                        low_cur_in = low_current_from(low_cur_ff, item.charge_percent);
                        if (item.charge_percent >= 7'(FULL_PCT)) begin
                           mode_in = ST_INIT;
                        end
                     end
                  end
               end
            end
            ST_CHG: begin
               if (!item.ac_present || !item.temp_valid) begin
                  mode_in = ST_INIT;
               end else if (!temp.charge_ok) begin
                  mode_in = ST_ERR;
               end else if (!item.status_valid) begin
                  mode_in = ST_INIT;
               end else if (item.alarm_bits[AL_OVER_TEMP]) begin
                  mode_in = ST_ERR;
               end else if (charged) begin
                  mode_in = ST_IDLE;
               end else if (item.charger_alarm || item.charge_timed_out) begin
                  mode_in = ST_INIT;
               end
            end
            ST_ERR: begin
               if (!item.ac_present) begin
                  mode_in = ST_INIT;
               end else if (item.status_valid && !item.alarm_bits[AL_OVER_TEMP] &&
                            item.temp_valid && temp.charge_ok) begin
                  mode_in = ST_CHG;
               end
            end
            ST_DIS: begin
               if (item.ac_present || item.host_off) begin
                  mode_in = ST_INIT;
               end else if ((item.temp_valid && !temp.discharge_ok) ||
                            (item.status_valid && (item.alarm_bits[AL_TERM_DISCHARGE] |
                                                   item.alarm_bits[AL_OVER_TEMP]))) begin
                  shut    = item.host_on;
                  mode_in = ST_INIT;
               end else if (item.soc_valid) begin
                  push = 1'b1;
                  if (avg_low) begin
                     shut    = item.host_on;
                     mode_in = ST_INIT;
                  end else if (item.charge_percent < 7'(NOTICE_PCT) && item.host_on &&
                               notice_elapsed > NOTICE_GAP_MS) begin
                     notice         = 1'b1;
                     notice_time_in = item.now_ms;
                  end
               end
            end
            default: begin
               if (!item.ac_present) begin
                  mode_in = item.host_on ? ST_DIS : ST_IDLE;
               end else if (item.charger_alarm) begin
                  mode_in = ST_BAD;
               end else if (!item.temp_valid) begin
                  low_cur_in = 1'b1;
                  mode_in    = ST_PRE;
               end else if (!temp.start_ok) begin
                  mode_in = ST_BAD;
               end else if (!item.status_valid || item.alarm_bits[AL_OVER_TEMP]) begin
                  mode_in = ST_BAD;
               end else if (charged) begin
                  mode_in = ST_IDLE;
               end else begin
                  mode_in = ST_IDLE;
                  if (item.soc_valid) begin
                     low_cur_in = low_current_from(low_cur_ff, item.charge_percent);
                     if (item.charge_percent < 7'(FULL_PCT)) begin
                        mode_in = ST_CHG;
                     end
                  end
               end
            end
         endcase
      end

      changed      = mode_in != cur;
      pre_start_in = pre_start_ff;
      enable_in    = enable_ff;
      led_in       = led_ff;
      if (changed) begin
         if (mode_in == ST_PRE) begin
            pre_start_in = item.now_ms;
         end
         if (mode_in == ST_PRE || mode_in == ST_CHG) begin
            led_in    = 1'b0;
            enable_in = 1'b1;
         end else if (mode_in == ST_ERR) begin
            led_in    = 1'b1;
            enable_in = 1'b1;
         end else begin
            led_in    = 1'b0;
            enable_in = 1'b0;
         end
      end
      // Staying in pre-charge implies the timeout has not run out, so only
      // entry with a zero timeout can drop the enable here.
      if (changed && mode_in == ST_PRE && precharge_timeout_ms == '0) begin
         enable_in = 1'b0;
      end
   end

   assign win_ctrl.clear = changed;
   assign win_ctrl.push  = push;
   assign win_ctrl.pct   = item.charge_percent;

   assign result.state_code       = mode_in;
   assign result.charge_enable    = enable_in;
   assign result.led_error        = led_in;
   assign result.low_current_mode = low_cur_in;
   assign result.shutdown_request = shut;
   assign result.low_notice       = notice;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= ST_INIT;
         pre_start_ff   <= '0;
         notice_time_ff <= '0;
         enable_ff      <= 1'b0;
         led_ff         <= 1'b0;
         low_cur_ff     <= 1'b0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         pre_start_ff   <= pre_start_in;
         notice_time_ff <= notice_time_in;
         enable_ff      <= enable_in;
         led_ff         <= led_in;
         low_cur_ff     <= low_cur_in;
      end
   end

endmodule

FILE: rtl/battery_charge_state_controller_core.sv
// Battery charge state controller: one poll tick in, one result beat out.
// A request beat is held in the input register; the charge machine's single
// pass ends in the result register, which drives rsp_tvalid. One beat per
// cycle while rsp_tready does not stall the result register.
// Reset (synchronous): state ST_INIT, levels and timers zero, window empty,
// registers at defaults; no clearing pass, requests are taken at once.
module battery_charge_state_controller_core
   import bcsc_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // ac_present, host_on, host_off, charger_alarm, charge_timed_out,
   // temp_valid, battery_temp_dk[16], status_valid, alarm_bits[16],
   // soc_valid, charge_percent[7], now_ms[32], one zero pad bit
   input  logic [79:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // state_code[3], charge_enable, led_error, low_current_mode,
   // shutdown_request, low_notice
   output logic [7:0]           rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic           s1_valid_ff, s1_valid_in;
   item_type       s1_item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_data_ff;
   cfg_type        cfg_ff;
   logic           advance;
   logic           req_fire;
   temp_flags_type temp_flags;
   win_ctrl_type   win_ctrl;
   logic           avg_low;
   result_type     result;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= item_type'(req_tdata);
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_charge_min_c   <= RST_START_MIN;
         cfg_ff.start_charge_max_c   <= RST_START_MAX;
         cfg_ff.charge_min_c         <= RST_CHARGE_MIN;
         cfg_ff.charge_max_c         <= RST_CHARGE_MAX;
         cfg_ff.discharge_min_c      <= RST_DIS_MIN;
         cfg_ff.discharge_max_c      <= RST_DIS_MAX;
         cfg_ff.precharge_timeout_ms <= RST_PRE_TMO;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_START_MIN:  cfg_ff.start_charge_min_c   <= csr_data[7:0];
            CSR_START_MAX:  cfg_ff.start_charge_max_c   <= csr_data[7:0];
            CSR_CHARGE_MIN: cfg_ff.charge_min_c         <= csr_data[7:0];
            CSR_CHARGE_MAX: cfg_ff.charge_max_c         <= csr_data[7:0];
            CSR_DIS_MIN:    cfg_ff.discharge_min_c      <= csr_data[7:0];
            CSR_DIS_MAX:    cfg_ff.discharge_max_c      <= csr_data[7:0];
            CSR_PRE_TMO:    cfg_ff.precharge_timeout_ms <= csr_data;
            default: begin
            end
         endcase
      end
   end

   bcsc_temp_eval u_temp (
      .battery_temp_dk (s1_item_ff.battery_temp_dk),
      .cfg             (cfg_ff),
      .flags           (temp_flags)
   );

   bcsc_soc_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctrl    (win_ctrl),
      .avg_low (avg_low)
   );

   bcsc_charge_fsm u_fsm (
      .clock                (clock),
      .reset                (reset),
      .advance              (advance),
      .item                 (s1_item_ff),
      .temp                 (temp_flags),
      .precharge_timeout_ms (cfg_ff.precharge_timeout_ms),
      .avg_low              (avg_low),
      .win_ctrl             (win_ctrl),
      .result               (result)
   );

endmodule
